>>> rtl/ubds_pkg.sv
// ----------------------------------------------------------------------------
// ubds_pkg
// Shared types, constants and helpers of the UART baud divisor solver.
// ----------------------------------------------------------------------------
package ubds_pkg;

  localparam int unsigned DivW = 48;
  localparam int unsigned DvsW = 32;
  localparam logic [31:0] Hundred = 32'd100;

  typedef enum logic [4:0] {
    S_IDLE,
    S_G1,
    S_NUM,
    S_DEN,
    S_CHK,
    S_M,
    S_N,
    S_SNUM,
    S_SDEN,
    S_PRE,
    S_G2,
    S_TN,
    S_TD,
    S_MUL,
    S_ACH,
    S_Q,
    S_THR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
    logic [DvsW-1:0] rem;
  } div_rsp_t;

  function automatic logic [2:0] code_of(input logic [2:0] div);
    logic [2:0] c;
    case (div)
      3'd1: c = 3'd5;
      3'd2: c = 3'd4;
      3'd3: c = 3'd3;
      3'd4: c = 3'd2;
      3'd5: c = 3'd1;
      3'd6: c = 3'd0;
      3'd7: c = 3'd6;
      default: c = 3'd5;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/ubds_div.sv
// ----------------------------------------------------------------------------
// ubds_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ubds_div
  import ubds_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivW-1:0] quot_q, quot_d;
  logic [DvsW-1:0] rem_q, rem_d, dvs_q;
  logic [5:0]      cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;
  logic [DvsW:0]   shifted;
  logic [DvsW+1:0] trial;

  assign shifted = {rem_q, quot_q[DivW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      cnt_d  = 6'(DivW - 1);
      run_d  = 1'b1;
    end else if (run_q) begin
      quot_d = {quot_q[DivW-2:0], ~trial[DvsW+1]};
      rem_d  = trial[DvsW+1] ? shifted[DvsW-1:0] : trial[DvsW-1:0];
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (req_i.start) dvs_q <= req_i.divisor;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> rtl/uart_baud_divisor_solver.sv
// ----------------------------------------------------------------------------
// uart_baud_divisor_solver
// Fractional baud divisor solver around one shared divider.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Busy then stays high
// while a sequencer drives one restoring divider through two Euclid
// reductions and the remaining divides. Each divide loads its operands on a
// start, produces 48 quotient bits and then raises done. Besides the divides
// a request passes three steps (range check, multiply, output). The divide
// count is the Euclid steps of both reductions plus eight, and four more
// when the terms must be scaled. A zero baud rate or a zero reference clock
// keeps busy high for one cycle only. The result shows on the output ports
// with valid_o for exactly one cycle, the first cycle after busy falls, and
// must be captured then.
module uart_baud_divisor_solver
  import ubds_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] baud_rate_i,
  output logic        valid_o,
  output logic [2:0]  prescale_code_o,
  output logic [15:0] increment_word_o,
  output logic [15:0] modulus_word_o,
  output logic [31:0] rate_error_o,
  output logic        accepted_o
);

  localparam logic [31:0] FracMax  = 32'((64'd1 << FRACTION_BITS) - 64'd1);
  localparam logic [31:0] FracMax7 = 32'(7 * ((64'd1 << FRACTION_BITS) - 64'd1));

  state_e state_q, state_d;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [31:0] ref_q, a_q, b_q, num_q, den_q, m_q, tn_q, td_q, thr_q;
  logic [23:0] baud_q;
  logic [47:0] prod_q, ach_q;
  logic [2:0]  pre_q;
  logic [15:0] q_q;
  logic        zero_q, pend_q, is_div;
  logic [31:0] qlo, nval;
  logic [47:0] err;

  ubds_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign qlo  = drsp.quot[31:0];
  assign nval = qlo + 32'd1;
  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start) state_d = ((baud_rate_i == '0) || (ref_q == '0)) ? S_OUT : S_G1;
      S_G1:   if (drsp.done && drsp.rem == '0) state_d = S_NUM;
      S_NUM:  if (drsp.done) state_d = S_DEN;
      S_DEN:  if (drsp.done) state_d = S_CHK;
      S_CHK:  state_d = ((num_q > FracMax7) || (den_q > FracMax)) ? S_M : S_PRE;
      S_M:    if (drsp.done) state_d = S_N;
      S_N:    if (drsp.done) state_d = S_SNUM;
      S_SNUM: if (drsp.done) state_d = S_SDEN;
      S_SDEN: if (drsp.done) state_d = S_PRE;
      S_PRE:  if (drsp.done) state_d = S_G2;
      S_G2:   if (drsp.done && drsp.rem == '0) state_d = S_TN;
      S_TN:   if (drsp.done) state_d = S_TD;
      S_TD:   if (drsp.done) state_d = S_MUL;
      S_MUL:  state_d = S_ACH;
      S_ACH:  if (drsp.done) state_d = S_Q;
      S_Q:    if (drsp.done) state_d = S_THR;
      S_THR:  if (drsp.done) state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    is_div = 1'b1;
    case (state_d)
      S_IDLE, S_CHK, S_MUL, S_OUT: is_div = 1'b0;
      default: is_div = 1'b1;
    endcase
  end

  always_comb begin
    dreq.start    = pend_q;
    dreq.dividend = '0;
    dreq.divisor  = 32'd1;
    case (state_q)
      S_G1, S_G2: begin
        dreq.dividend = {16'd0, a_q};
        dreq.divisor  = b_q;
      end
      S_NUM, S_TN: begin
        dreq.dividend = {16'd0, ref_q};
        dreq.divisor  = a_q;
      end
      S_DEN: begin
        dreq.dividend = {20'd0, baud_q, 4'd0};
        dreq.divisor  = a_q;
      end
      S_M: begin
        dreq.dividend = {16'd0, num_q - 32'd1};
        dreq.divisor  = FracMax7;
      end
      S_N: begin
        dreq.dividend = {16'd0, den_q - 32'd1};
        dreq.divisor  = FracMax;
      end
      S_SNUM: begin
        dreq.dividend = {16'd0, num_q};
        dreq.divisor  = m_q;
      end
      S_SDEN: begin
        dreq.dividend = {16'd0, den_q};
        dreq.divisor  = m_q;
      end
      S_PRE: begin
        dreq.dividend = {16'd0, num_q - 32'd1};
        dreq.divisor  = FracMax;
      end
      S_TD: begin
        dreq.dividend = {12'd0, num_q, 4'd0};
        dreq.divisor  = a_q;
      end
      S_ACH: begin
        dreq.dividend = prod_q;
        dreq.divisor  = td_q;
      end
      S_Q: begin
        dreq.dividend = {16'd0, num_q};
        dreq.divisor  = {29'd0, pre_q};
      end
      S_THR: begin
        dreq.dividend = {24'd0, baud_q};
        dreq.divisor  = Hundred;
      end
      default: begin
        dreq.dividend = '0;
        dreq.divisor  = 32'd1;
      end
    endcase
  end

  assign err = (ach_q >= {24'd0, baud_q}) ? (ach_q - {24'd0, baud_q})
                                          : ({24'd0, baud_q} - ach_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      valid_o <= 1'b0;
      ref_q   <= 32'd80000000;
    end else begin
      state_q <= state_d;
      pend_q  <= is_div && ((state_q != state_d) || drsp.done);
      valid_o <= (state_q == S_OUT);
      if (cfg_we_i) ref_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (start) begin
        baud_q <= baud_rate_i;
        zero_q <= (baud_rate_i == '0) || (ref_q == '0);
        a_q    <= ref_q;
        b_q    <= {4'd0, baud_rate_i, 4'd0};
      end
      S_G1, S_G2: if (drsp.done) begin
        a_q <= b_q;
        b_q <= drsp.rem;
      end
      S_NUM:  if (drsp.done) num_q <= qlo;
      S_DEN:  if (drsp.done) den_q <= qlo;
      S_M:    if (drsp.done) m_q <= nval;
      S_N:    if (drsp.done && nval > m_q) m_q <= nval;
      S_SNUM: if (drsp.done) num_q <= (qlo == '0) ? 32'd1 : qlo;
      S_SDEN: if (drsp.done) den_q <= (qlo == '0) ? 32'd1 : qlo;
      S_PRE: if (drsp.done) begin
        pre_q <= nval[2:0];
        a_q   <= ref_q;
        b_q   <= {num_q[27:0], 4'd0};
      end
      S_TN:   if (drsp.done) tn_q <= qlo;
      S_TD:   if (drsp.done) td_q <= qlo;
      S_MUL:  prod_q <= {16'd0, tn_q} * {32'd0, den_q[15:0]};
      S_ACH:  if (drsp.done) ach_q <= drsp.quot;
      S_Q:    if (drsp.done) q_q <= qlo[15:0];
      S_THR:  if (drsp.done) thr_q <= 32'(qlo * 32'd3);
      S_OUT: begin
        if (zero_q) begin
          prescale_code_o  <= '0;
          increment_word_o <= '0;
          modulus_word_o   <= '0;
          rate_error_o     <= '0;
          accepted_o       <= 1'b0;
        end else begin
          prescale_code_o  <= code_of(pre_q);
          increment_word_o <= den_q[15:0] - 16'd1;
          modulus_word_o   <= q_q - 16'd1;
          rate_error_o     <= (err[47:32] != '0) ? 32'hFFFF_FFFF : err[31:0];
          accepted_o       <= (err < {16'd0, thr_q});
        end
      end
      default: ;
    endcase
  end

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after request");
  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q) == S_OUT) else $error("result without final step");
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy || $past(start)) else $error("result while solving");

endmodule

>>> test/uart_baud_divisor_solver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_solver_tb
// Self-checking bench for the UART baud divisor solver: directed and random
// baud requests under several reference clocks and start-gap patterns, each
// result compared field by field against a local divisor predictor.
// ----------------------------------------------------------------------------
module uart_baud_divisor_solver_tb
  import ubds_pkg::*;
();

  localparam int unsigned FracBits  = 16;
  localparam logic [31:0] FracMax   = (32'd1 << FracBits) - 32'd1;
  localparam int unsigned IdleLimit = 200000;
  localparam int unsigned DrainWait = 200;

  typedef struct packed {
    logic [2:0]  code;
    logic [15:0] incr;
    logic [15:0] modulus;
    logic [31:0] err;
    logic        ok;
  } divisor_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [23:0] baud_rate_i = '0;
  logic        valid_o;
  logic [2:0]  prescale_code_o;
  logic [15:0] increment_word_o;
  logic [15:0] modulus_word_o;
  logic [31:0] rate_error_o;
  logic        accepted_o;

  logic [31:0] refclk_hz = 32'd80000000;
  divisor_t    pending_divisors[$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned idle_cycles = 0;

  uart_baud_divisor_solver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start           (start),
    .busy            (busy),
    .baud_rate_i     (baud_rate_i),
    .valid_o         (valid_o),
    .prescale_code_o (prescale_code_o),
    .increment_word_o(increment_word_o),
    .modulus_word_o  (modulus_word_o),
    .rate_error_o    (rate_error_o),
    .accepted_o      (accepted_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [31:0] euclid(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic divisor_t solve_divisor(logic [31:0] refclk, logic [23:0] baud);
    divisor_t    d;
    logic [31:0] b16, g, num, den, m, n, mx, pre, g2, tn, td, thr;
    logic [63:0] achieved, err;
    d = '0;
    if (baud == 0 || refclk == 0) return d;
    b16 = {4'd0, baud, 4'd0};
    g = euclid(refclk, b16);
    num = refclk / g;
    den = b16 / g;
    if (num > FracMax * 32'd7 || den > FracMax) begin
      m = (num - 32'd1) / (FracMax * 32'd7) + 32'd1;
      n = (den - 32'd1) / FracMax + 32'd1;
      mx = (m > n) ? m : n;
      num = num / mx;
      den = den / mx;
      if (num == 0) num = 32'd1;
      if (den == 0) den = 32'd1;
    end
    pre = (num - 32'd1) / FracMax + 32'd1;
    g2 = euclid(refclk, num << 4);
    tn = refclk / g2;
    td = (num << 4) / g2;
    achieved = ({32'd0, tn} * {32'd0, den}) / {32'd0, td};
    err = (achieved >= {40'd0, baud}) ? achieved - baud : {40'd0, baud} - achieved;
    thr = ({8'd0, baud} / 32'd100) * 32'd3;
    d.code = (pre >= 1 && pre <= 7) ? code_of(pre[2:0]) : code_of(3'd0);
    d.incr = den[15:0] - 16'd1;
    d.modulus = 16'(num / pre - 32'd1);
    d.err = (err > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : err[31:0];
    d.ok = err < {32'd0, thr};
    return d;
  endfunction

  task automatic request_baud(logic [23:0] baud);
    bit taken;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      baud_rate_i <= 24'($urandom);
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start <= 1'b1;
    baud_rate_i <= baud;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    pending_divisors.push_back(solve_divisor(refclk_hz, baud));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    baud_rate_i <= 24'($urandom);
    while (pending_divisors.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_refclk(logic [31:0] hz);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= hz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= $urandom;
    refclk_hz = hz;
  endtask

  function automatic logic [23:0] pick_baud();
    int unsigned sel;
    logic [23:0] common[8] = '{24'd300, 24'd1200, 24'd9600, 24'd19200, 24'd38400,
                               24'd57600, 24'd115200, 24'd921600};
    sel = $urandom_range(9);
    if (sel < 3) return common[$urandom_range(7)];
    if (sel < 6) return 24'($urandom_range(1000000, 1));
    if (sel < 8) return 24'($urandom);
    return 24'($urandom_range(200));
  endfunction

  task automatic test_default_refclk();
    logic [23:0] dir[11] = '{24'd1, 24'hFFFFFF, 24'd0, 24'd115200, 24'd9600, 24'd2,
                             24'h800000, 24'h555555, 24'hAAAAAA, 24'd5000000, 24'd3};
    foreach (dir[i]) request_baud(dir[i]);
  endtask

  task automatic test_refclk_extremes();
    write_refclk(32'hFFFF_FFFF);
    request_baud(24'd1);
    request_baud(24'hFFFFFF);
    request_baud(24'd115200);
    write_refclk(32'd1);
    request_baud(24'd1);
    request_baud(24'hFFFFFF);
    request_baud(24'd9600);
    write_refclk(32'd0);
    request_baud(24'd115200);
    request_baud(24'd0);
    write_refclk(32'd16);
    request_baud(24'd1);
    request_baud(24'd7);
  endtask

  task automatic test_random_phase(int unsigned pct, int unsigned count);
    idle_pct = pct;
    case ($urandom_range(3))
      0: write_refclk(32'd80000000);
      1: write_refclk(32'd48000000);
      2: write_refclk($urandom_range(200000000, 1000000));
      default: write_refclk($urandom);
    endcase
    repeat (count) request_baud(pick_baud());
  endtask

  always @(negedge clk_i) begin
    divisor_t d;
    if (rst_ni && valid_o) begin
      if (pending_divisors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        d = pending_divisors.pop_front();
        if (d.code != prescale_code_o || d.incr != increment_word_o ||
            d.modulus != modulus_word_o || d.err != rate_error_o ||
            d.ok != accepted_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp code=%0d incr=%0d mod=%0d err=%0d ok=%0d, ",
                      "got %0d %0d %0d %0d %0d"},
                     d.code, d.incr, d.modulus, d.err, d.ok, prescale_code_o,
                     increment_word_o, modulus_word_o, rate_error_o, accepted_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (valid_o || (start && !busy)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("[uart_baud_divisor_solver] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_refclk();
    test_refclk_extremes();
    test_random_phase(0, 70);
    test_random_phase(47, 70);
    test_random_phase(22, 70);
    test_random_phase(0, 70);
    test_random_phase(47, 70);
    test_random_phase(22, 70);
    test_random_phase(0, 65);
    test_random_phase(47, 65);
    drain_results();
    if (mismatches == 0) begin
      $display("[uart_baud_divisor_solver] OK");
    end else begin
      $display("[uart_baud_divisor_solver] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ubds_pkg.sv
rtl/ubds_div.sv
rtl/uart_baud_divisor_solver.sv
test/uart_baud_divisor_solver_tb.sv
